// ===== rtl/wss_pkg.sv =====
// Shared types, constants and helpers of the weighted signature scan.
// Used by the front queue, the match engine, the tally pipeline, the top level
// and the testbench.
`default_nettype none

package wss_pkg;

  // Table size; the port and field widths of the block are sized for these values.
  localparam int NUM_PATTERNS    = 64;
  localparam int MAX_PATTERN_LEN = 32;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_DETECT     = 3'd0,
    REG_STRONG     = 3'd1,
    REG_WEAK       = 3'd2,
    REG_SIZE_LIMIT = 3'd3,
    REG_SIZE_BONUS = 3'd4
  } cfg_reg_e;

  // Four-level verdict reported with each file.
  typedef enum logic [1:0] {
    VERDICT_NONE     = 2'd0,
    VERDICT_UNLIKELY = 2'd1,
    VERDICT_POSSIBLE = 2'd2,
    VERDICT_LIKELY   = 2'd3
  } verdict_e;

  // Kind of a queued item, set when the item is taken in.
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_SCAN = 1'b1
  } kind_e;

  // One classified item as it waits in the queue.
  typedef struct packed {
    kind_e       kind;
    logic [5:0]  slot;
    logic [4:0]  pos;
    logic        pos_ok;
    logic [7:0]  chr;
    logic [5:0]  len;
    logic [7:0]  weight;
    logic [7:0]  data;
    logic        last;
  } item_t;

  // Control that travels with a scanned byte down the tally pipeline.
  typedef struct packed {
    logic valid;
    logic last;
    logic over;
  } scan_ctl_t;

  // Totals of one finished file, handed to the output stage.
  typedef struct packed {
    logic        valid;
    logic        over;
    logic [15:0] score;
    logic [6:0]  count;
  } tally_res_t;

  localparam logic [15:0] SCORE_MAX   = 16'hFFFF;
  localparam logic [6:0]  COUNT_MAX   = 7'd127;
  localparam logic [7:0]  CHAR_UP_A   = 8'h41;
  localparam logic [7:0]  CHAR_UP_Z   = 8'h5A;
  localparam logic [7:0]  CASE_OFFSET = 8'h20;

  // Fold upper-case ASCII letters to lower case; other bytes pass unchanged.
  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/weighted_signature_scan.sv =====
// Weighted signature scan: one item per clock unless stalled; result on each file's last byte.
// A load item writes one pattern character together with the slot's length and
// weight; a scan item compares one file byte against every table cell at once.
// The block takes one item per cycle unless its queue is full; its queue of four
// items lets input flow on while the output is stalled, until it fills. The
// result of a file passes through one match stage, three stages of the weight
// adder tree and totals, and the output stage that adds the size bonus and
// grades the score.
// Depends on wss_pkg, wss_front, wss_match and wss_tally.
`default_nettype none

module weighted_signature_scan import wss_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [5:0]  slot_i,
  input  wire logic [4:0]  char_pos_i,
  input  wire logic [7:0]  pattern_char_i,
  input  wire logic [5:0]  pattern_len_i,
  input  wire logic [7:0]  weight_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      score_o,
  output logic [6:0]       match_count_o,
  output logic             is_client_o,
  output logic [1:0]       verdict_o
);

  localparam logic [15:0] DETECT_RST = 16'd50;
  localparam logic [15:0] STRONG_RST = 16'd80;
  localparam logic [15:0] WEAK_RST   = 16'd20;
  localparam logic [31:0] LIMIT_RST  = 32'd100000;
  localparam logic [7:0]  BONUS_RST  = 8'd5;

  localparam logic [6:0]  MATCH_CAP = (NUM_PATTERNS < 127) ? 7'(NUM_PATTERNS) : 7'd127;
  localparam logic [15:0] BONUS_MAX = 16'd255;

  logic [15:0] detect_q, strong_q, weak_q;
  logic [31:0] limit_q;
  logic [7:0]  bonus_q;

  logic        head_valid;
  item_t       head;
  logic        pop;
  logic        adv;
  scan_ctl_t   s1_ctl;
  logic [7:0]  s1_wt [NUM_PATTERNS];
  logic [NUM_PATTERNS-1:0] s1_hit;
  tally_res_t  fin;

  logic [16:0] bonus_sum;
  logic [15:0] score_d;
  logic [1:0]  verdict_d;

  logic        out_valid_q;
  logic [15:0] score_q;
  logic [6:0]  count_q;
  logic        client_q;
  logic [1:0]  verdict_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_q <= DETECT_RST;
      strong_q <= STRONG_RST;
      weak_q   <= WEAK_RST;
      limit_q  <= LIMIT_RST;
      bonus_q  <= BONUS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DETECT:     detect_q <= cfg_data_i[15:0];
        REG_STRONG:     strong_q <= cfg_data_i[15:0];
        REG_WEAK:       weak_q   <= cfg_data_i[15:0];
        REG_SIZE_LIMIT: limit_q  <= cfg_data_i;
        REG_SIZE_BONUS: bonus_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // The back end moves whenever the output register can take a result.
  assign adv = !(out_valid_q && out_stall_i);

  wss_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .slot_i        (slot_i),
    .char_pos_i    (char_pos_i),
    .pattern_char_i(pattern_char_i),
    .pattern_len_i (pattern_len_i),
    .weight_i      (weight_i),
    .data_byte_i   (data_byte_i),
    .last_i        (last_i),
    .head_valid_o  (head_valid),
    .head_o        (head),
    .pop_i         (pop)
  );

  wss_match u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .size_limit_i(limit_q),
    .item_valid_i(head_valid),
    .item_i      (head),
    .pop_o       (pop),
    .s1_ctl_o    (s1_ctl),
    .s1_wt_o     (s1_wt),
    .s1_hit_o    (s1_hit)
  );

  wss_tally u_tally (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .s1_ctl_i(s1_ctl),
    .s1_wt_i (s1_wt),
    .s1_hit_i(s1_hit),
    .fin_o   (fin)
  );

  // Size bonus, then the grading against the three thresholds.
  always_comb begin
    bonus_sum = 17'(fin.score) + 17'(bonus_q);
    score_d   = fin.score;
    if (fin.over) begin
      score_d = (bonus_sum > 17'(SCORE_MAX)) ? SCORE_MAX : bonus_sum[15:0];
    end
    if (score_d >= strong_q) begin
      verdict_d = VERDICT_LIKELY;
    end else if (score_d >= detect_q) begin
      verdict_d = VERDICT_POSSIBLE;
    end else if (score_d >= weak_q) begin
      verdict_d = VERDICT_UNLIKELY;
    end else begin
      verdict_d = VERDICT_NONE;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && fin.valid) begin
      score_q   <= score_d;
      count_q   <= fin.count;
      client_q  <= (score_d >= detect_q);
      verdict_q <= verdict_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign score_o       = score_q;
  assign match_count_o = count_q;
  assign is_client_o   = client_q;
  assign verdict_o     = verdict_q;

  // A client always grades as possible or likely.
  a_client_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_client_o |->
      verdict_o == VERDICT_POSSIBLE || verdict_o == VERDICT_LIKELY)
    else $error("client flag without a matching verdict");

  // No more slots can be found than the table holds.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> match_count_o <= MATCH_CAP)
    else $error("match count above the table size");

  // Without any match the score is at most the size bonus.
  a_empty_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && match_count_o == 7'd0 |-> score_o <= BONUS_MAX)
    else $error("score left over from an earlier file");

endmodule

`default_nettype wire

// ===== rtl/wss_front.sv =====
// Front end: accepts items, classifies them and holds them in a short queue.
// Depends on wss_pkg for the item type and the case folding helper.
`default_nettype none

module wss_front import wss_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       req_type_i,
  input  wire logic [5:0] slot_i,
  input  wire logic [4:0] char_pos_i,
  input  wire logic [7:0] pattern_char_i,
  input  wire logic [5:0] pattern_len_i,
  input  wire logic [7:0] weight_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_i,
  output logic            head_valid_o,
  output item_t           head_o,
  input  wire logic       pop_i
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  item_t           fifo_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  item_t           item_c;
  logic            keep;
  logic            push;

  // Classify the incoming item; loads aimed past the table are dropped here.
  always_comb begin
    item_c.kind   = req_type_i ? KIND_SCAN : KIND_LOAD;
    item_c.slot   = slot_i;
    item_c.pos    = char_pos_i;
    item_c.pos_ok = int'(char_pos_i) < MAX_PATTERN_LEN;
    item_c.chr    = fold_lower(pattern_char_i);
    item_c.len    = pattern_len_i;
    item_c.weight = weight_i;
    item_c.data   = fold_lower(data_byte_i);
    item_c.last   = last_i;
    keep          = req_type_i || (int'(slot_i) < NUM_PATTERNS);
  end

  assign in_stall_o   = (cnt_q == CntW'(Depth));
  assign push         = in_valid_i && !in_stall_o && keep;
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = fifo_q[rd_ptr_q];

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  // Queue pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_c;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wss_match.sv =====
// Match engine: pattern table cells, shift-and partial-match vectors per slot.
// Depends on wss_pkg; takes items from the front queue and feeds wss_tally.
`default_nettype none

module wss_match import wss_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,
  input  wire logic [31:0] size_limit_i,
  input  wire logic        item_valid_i,
  input  wire item_t       item_i,
  output logic             pop_o,
  output scan_ctl_t        s1_ctl_o,
  output logic [7:0]       s1_wt_o [NUM_PATTERNS],
  output logic [NUM_PATTERNS-1:0] s1_hit_o
);

  localparam int LenW = $clog2(MAX_PATTERN_LEN + 1);
  localparam int PosW = $clog2(MAX_PATTERN_LEN);
  localparam int MaxL = MAX_PATTERN_LEN;

  logic [7:0]       chars_q [NUM_PATTERNS][MaxL];
  logic [LenW-1:0]  len_q   [NUM_PATTERNS];
  logic [7:0]       wt_q    [NUM_PATTERNS];
  logic [MaxL-1:0]  pm_q    [NUM_PATTERNS];
  logic [NUM_PATTERNS-1:0] found_q;
  logic [31:0]      byte_cnt_q;

  logic [MaxL-1:0]  eq_c    [NUM_PATTERNS];
  logic [MaxL-1:0]  vec_c   [NUM_PATTERNS];
  logic [PosW-1:0]  tail_c  [NUM_PATTERNS];
  logic [NUM_PATTERNS-1:0] act_c, hit_c;
  logic [7:0]       wtm_c   [NUM_PATTERNS];
  logic [LenW-1:0]  len_clamp;
  logic             scan_pop, load_pop;
  logic             over_c;

  scan_ctl_t        s1_ctl_q;
  logic [7:0]       s1_wt_q [NUM_PATTERNS];
  logic [NUM_PATTERNS-1:0] s1_hit_q;

  assign pop_o    = item_valid_i && adv_i;
  assign scan_pop = pop_o && (item_i.kind == KIND_SCAN);
  assign load_pop = pop_o && (item_i.kind == KIND_LOAD);

  // Length written by a load is clamped to the longest pattern.
  assign len_clamp = (int'(item_i.len) > MaxL) ? LenW'(MaxL) : LenW'(item_i.len);

  // The file is over the size limit once this byte makes it longer than the limit.
  assign over_c = (byte_cnt_q >= size_limit_i) && (size_limit_i != '1);

  // Every cell compares its character with the byte; each slot steps its vector.
  always_comb begin
    for (int s = 0; s < NUM_PATTERNS; s++) begin
      for (int j = 0; j < MaxL; j++) begin
        eq_c[s][j] = (chars_q[s][j] == item_i.data) && (j < int'(len_q[s]));
      end
      vec_c[s]  = {pm_q[s][MaxL-2:0], 1'b1} & eq_c[s];
      tail_c[s] = PosW'(len_q[s] - LenW'(1));
      act_c[s]  = scan_pop && (len_q[s] != '0) && !found_q[s];
      hit_c[s]  = act_c[s] && vec_c[s][tail_c[s]];
      wtm_c[s]  = hit_c[s] ? wt_q[s] : 8'd0;
    end
  end

  // Slot lengths, weights and the per-file scan state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_PATTERNS; s++) begin
        len_q[s] <= '0;
        wt_q[s]  <= '0;
        pm_q[s]  <= '0;
      end
      found_q    <= '0;
      byte_cnt_q <= '0;
    end else begin
      for (int s = 0; s < NUM_PATTERNS; s++) begin
        if (load_pop && int'(item_i.slot) == s) begin
          len_q[s] <= len_clamp;
          wt_q[s]  <= item_i.weight;
        end
        if (scan_pop && item_i.last) begin
          pm_q[s]    <= '0;
          found_q[s] <= 1'b0;
        end else if (act_c[s]) begin
          pm_q[s]    <= vec_c[s];
          found_q[s] <= hit_c[s];
        end
      end
      if (scan_pop) begin
        if (item_i.last) begin
          byte_cnt_q <= '0;
        end else if (byte_cnt_q != '1) begin
          byte_cnt_q <= byte_cnt_q + 32'd1;
        end
      end
    end
  end

  // Pattern characters; each cell is written when a load addresses it.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NUM_PATTERNS; s++) begin
      for (int j = 0; j < MaxL; j++) begin
        if (load_pop && item_i.pos_ok && int'(item_i.slot) == s
            && int'(item_i.pos) == j) begin
          chars_q[s][j] <= item_i.chr;
        end
      end
    end
  end

  // Stage register toward the tally: control with reset, masked weights and hits without.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
    end else if (adv_i) begin
      s1_ctl_q.valid <= scan_pop;
      s1_ctl_q.last  <= item_i.last;
      s1_ctl_q.over  <= over_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int s = 0; s < NUM_PATTERNS; s++) begin
        s1_wt_q[s] <= wtm_c[s];
      end
      s1_hit_q <= hit_c;
    end
  end

  assign s1_ctl_o = s1_ctl_q;
  assign s1_wt_o  = s1_wt_q;
  assign s1_hit_o = s1_hit_q;

endmodule

`default_nettype wire

// ===== rtl/wss_tally.sv =====
// Tally pipeline: registered adder tree over newly found slots and the file totals.
// Depends on wss_pkg; fed by wss_match, read by the top-level output stage.
`default_nettype none

module wss_tally import wss_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,
  input  wire scan_ctl_t   s1_ctl_i,
  input  wire logic [7:0]  s1_wt_i [NUM_PATTERNS],
  input  wire logic [NUM_PATTERNS-1:0] s1_hit_i,
  output tally_res_t       fin_o
);

  localparam int Group = 8;
  localparam int Ng1   = (NUM_PATTERNS + Group - 1) / Group;
  localparam int Ng2   = (Ng1 + Group - 1) / Group;

  logic [10:0] l1_sum_d [Ng1], l1_sum_q [Ng1];
  logic [3:0]  l1_cnt_d [Ng1], l1_cnt_q [Ng1];
  logic [13:0] l2_sum_d [Ng2], l2_sum_q [Ng2];
  logic [6:0]  l2_cnt_d [Ng2], l2_cnt_q [Ng2];
  scan_ctl_t   s2_ctl_q, s3_ctl_q;
  logic [16:0] tot_sum;
  logic [9:0]  tot_cnt;
  logic [15:0] new_score;
  logic [6:0]  new_count;
  logic [15:0] acc_score_q;
  logic [6:0]  acc_count_q;
  tally_res_t  fin_q;

  // First level: groups of eight slots.
  always_comb begin
    for (int g = 0; g < Ng1; g++) begin
      l1_sum_d[g] = '0;
      l1_cnt_d[g] = '0;
      for (int k = 0; k < Group; k++) begin
        if (g * Group + k < NUM_PATTERNS) begin
          l1_sum_d[g] = l1_sum_d[g] + 11'(s1_wt_i[g * Group + k]);
          l1_cnt_d[g] = l1_cnt_d[g] + 4'(s1_hit_i[g * Group + k]);
        end
      end
    end
  end

  // Second level: groups of eight first-level sums.
  always_comb begin
    for (int g = 0; g < Ng2; g++) begin
      l2_sum_d[g] = '0;
      l2_cnt_d[g] = '0;
      for (int k = 0; k < Group; k++) begin
        if (g * Group + k < Ng1) begin
          l2_sum_d[g] = l2_sum_d[g] + 14'(l1_sum_q[g * Group + k]);
          l2_cnt_d[g] = l2_cnt_d[g] + 7'(l1_cnt_q[g * Group + k]);
        end
      end
    end
  end

  // Last level joins the running totals, saturating both.
  always_comb begin
    tot_sum = 17'(acc_score_q);
    tot_cnt = 10'(acc_count_q);
    for (int g = 0; g < Ng2; g++) begin
      tot_sum = tot_sum + 17'(l2_sum_q[g]);
      tot_cnt = tot_cnt + 10'(l2_cnt_q[g]);
    end
    new_score = (tot_sum > 17'(SCORE_MAX)) ? SCORE_MAX : tot_sum[15:0];
    new_count = (tot_cnt > 10'(COUNT_MAX)) ? COUNT_MAX : tot_cnt[6:0];
  end

  // Tree stage registers.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      l1_sum_q <= l1_sum_d;
      l1_cnt_q <= l1_cnt_d;
      l2_sum_q <= l2_sum_d;
      l2_cnt_q <= l2_cnt_d;
    end
  end

  // Control of the tree stages, running totals and the finished-file record.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q    <= '0;
      s3_ctl_q    <= '0;
      acc_score_q <= '0;
      acc_count_q <= '0;
      fin_q       <= '0;
    end else if (adv_i) begin
      s2_ctl_q    <= s1_ctl_i;
      s3_ctl_q    <= s2_ctl_q;
      fin_q.valid <= s3_ctl_q.valid && s3_ctl_q.last;
      if (s3_ctl_q.valid) begin
        if (s3_ctl_q.last) begin
          fin_q.score <= new_score;
          fin_q.count <= new_count;
          fin_q.over  <= s3_ctl_q.over;
          acc_score_q <= '0;
          acc_count_q <= '0;
        end else begin
          acc_score_q <= new_score;
          acc_count_q <= new_count;
        end
      end
    end
  end

  assign fin_o = fin_q;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for weighted_signature_scan: loads pattern tables,
// streams files through the scan channel and checks each file's tally.
// Depends on wss_pkg and the weighted_signature_scan RTL.
`timescale 1ns / 1ps

module testbench;
  import wss_pkg::*;

  localparam int NUM_SLOTS      = 64;
  localparam int MAX_LEN        = 32;
  localparam int RANDOM_ITEMS   = 500;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 50;
  localparam logic [7:0] UPPER_A  = 8'h41;
  localparam logic [7:0] UPPER_Z  = 8'h5A;
  localparam logic [7:0] LOWER_A  = 8'h61;
  localparam logic [7:0] LOWER_Z  = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;
  localparam logic [2:0] REG_SPARE = 3'd7;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SPARSE,
    STALL_WAVE,
    STALL_HEAVY
  } stall_mode_e;

  typedef struct {
    kind_e      kind;
    logic [5:0] slot;
    logic [4:0] pos;
    logic [7:0] chr;
    logic [5:0] len;
    logic [7:0] wt;
    logic [7:0] data;
    logic       last;
  } req_t;

  typedef struct packed {
    logic [15:0] score;
    logic [6:0]  count;
    logic        client;
    verdict_e    grade;
  } file_tally_t;

  typedef logic [7:0] byte_q_t[$];

  // Block ports.
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [2:0]  cfg_index_i    = '0;
  logic [31:0] cfg_data_i     = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic        req_type_i     = 1'b0;
  logic [5:0]  slot_i         = '0;
  logic [4:0]  char_pos_i     = '0;
  logic [7:0]  pattern_char_i = '0;
  logic [5:0]  pattern_len_i  = '0;
  logic [7:0]  weight_i       = '0;
  logic [7:0]  data_byte_i    = '0;
  logic        last_i         = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [15:0] score_o;
  logic [6:0]  match_count_o;
  logic        is_client_o;
  logic [1:0]  verdict_o;

  // Scan model state, starting from the reset values.
  logic [7:0]         pat_char   [NUM_SLOTS][MAX_LEN];
  logic [MAX_LEN-1:0] pat_written[NUM_SLOTS] = '{default: '0};
  logic [5:0]         pat_len    [NUM_SLOTS] = '{default: '0};
  logic [7:0]         pat_wt     [NUM_SLOTS] = '{default: '0};
  logic [31:0]        prefix_vec [NUM_SLOTS] = '{default: '0};
  logic               slot_hit   [NUM_SLOTS] = '{default: 1'b0};
  logic [31:0]        bytes_seen = '0;
  int unsigned        run_score  = 0;
  int unsigned        hit_total  = 0;
  logic [15:0]        thr_detect = 16'd50;
  logic [15:0]        thr_strong = 16'd80;
  logic [15:0]        thr_weak   = 16'd20;
  logic [31:0]        size_lim   = 32'd100000;
  logic [7:0]         size_bonus = 8'd5;

  file_tally_t expected_tallies[$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned burst_left     = 0;
  int unsigned gap_max        = 0;
  int unsigned quiet_cycles   = 0;
  stall_mode_e stall_mode     = STALL_NONE;
  int unsigned stall_left     = 0;
  logic [3:0]  wave_count     = '0;

  weighted_signature_scan u_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [7:0] to_lower_byte(input logic [7:0] c);
    if (c >= UPPER_A && c <= UPPER_Z) begin
      return c + CASE_GAP;
    end
    return c;
  endfunction

  // Turns a lower-case letter to upper case half of the time.
  function automatic logic [7:0] random_case(input logic [7:0] c);
    if (c >= LOWER_A && c <= LOWER_Z && $urandom_range(0, 1) == 1) begin
      return c - CASE_GAP;
    end
    return c;
  endfunction

  // Number of characters written without a hole from position zero.
  function automatic int unsigned written_prefix(input int unsigned s);
    int unsigned n;
    n = 0;
    while (n < MAX_LEN && pat_written[s][n]) begin
      n++;
    end
    return n;
  endfunction

  // Advances the scan model by one accepted item and queues a tally on the last byte.
  function automatic void update_scan_model(input req_t r);
    logic [7:0]  c;
    logic [31:0] eq;
    logic [31:0] v;
    int unsigned total;
    file_tally_t t;
    if (r.kind == KIND_LOAD) begin
      pat_char[r.slot][r.pos] = to_lower_byte(r.chr);
      pat_len[r.slot] = (r.len > MAX_LEN) ? 6'(MAX_LEN) : r.len;
      pat_wt[r.slot] = r.wt;
      return;
    end
    c = to_lower_byte(r.data);
    if (bytes_seen != 32'hFFFF_FFFF) begin
      bytes_seen++;
    end
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (pat_len[s] != 0 && !slot_hit[s]) begin
        eq = '0;
        for (int j = 0; j < pat_len[s]; j++) begin
          if (pat_char[s][j] == c) begin
            eq[j] = 1'b1;
          end
        end
        v = ((prefix_vec[s] << 1) | 32'd1) & eq;
        prefix_vec[s] = v;
        if (v[pat_len[s] - 1]) begin
          slot_hit[s] = 1'b1;
          run_score = run_score + pat_wt[s];
          if (run_score > 65535) begin
            run_score = 65535;
          end
          if (hit_total < 127) begin
            hit_total++;
          end
        end
      end
    end
    if (!r.last) begin
      return;
    end
    // Close the file: size bonus, grading, then a fresh scan state.
    total = run_score;
    if (bytes_seen > size_lim) begin
      total = total + size_bonus;
      if (total > 65535) begin
        total = 65535;
      end
    end
    t.score = total[15:0];
    t.count = hit_total[6:0];
    t.client = (total >= thr_detect);
    if (total >= thr_strong) begin
      t.grade = VERDICT_LIKELY;
    end else if (total >= thr_detect) begin
      t.grade = VERDICT_POSSIBLE;
    end else if (total >= thr_weak) begin
      t.grade = VERDICT_UNLIKELY;
    end else begin
      t.grade = VERDICT_NONE;
    end
    expected_tallies = {expected_tallies, t};
    foreach (prefix_vec[s]) begin
      prefix_vec[s] = '0;
      slot_hit[s] = 1'b0;
    end
    bytes_seen = '0;
    run_score = 0;
    hit_total = 0;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // Every field not used by an item's kind carries random content.
  function automatic req_t random_req();
    req_t r;
    r.kind = KIND_SCAN;
    r.slot = 6'($urandom_range(0, 63));
    r.pos  = 5'($urandom_range(0, 31));
    r.chr  = 8'($urandom_range(0, 255));
    r.len  = 6'($urandom_range(0, 63));
    r.wt   = 8'($urandom_range(0, 255));
    r.data = 8'($urandom_range(0, 255));
    r.last = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Sends one item in bursts with random gaps, and updates the model once it is taken.
  task automatic send_req(input req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    req_type_i     <= r.kind;
    slot_i         <= r.slot;
    char_pos_i     <= r.pos;
    pattern_char_i <= r.chr;
    pattern_len_i  <= r.len;
    weight_i       <= r.wt;
    data_byte_i    <= r.data;
    last_i         <= r.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    update_scan_model(r);
    items_sent++;
  endtask

  // Writes one table character; the length is cut back so that it never
  // covers a character that was not written.
  task automatic load_char(input int unsigned s, input int unsigned pos, input logic [7:0] c,
                           input int unsigned len, input logic [7:0] wt);
    req_t r;
    int unsigned pre;
    pat_written[s][pos] = 1'b1;
    pre = written_prefix(s);
    if (pre < MAX_LEN && len > pre) begin
      len = pre;
    end
    r = random_req();
    r.kind = KIND_LOAD;
    r.slot = 6'(s);
    r.pos  = 5'(pos);
    r.chr  = c;
    r.len  = 6'(len);
    r.wt   = wt;
    send_req(r);
  endtask

  // Loads a whole pattern into a random slot, either growing its length with
  // each character or keeping the old length until the final character.
  task automatic load_random_pattern(input bit full_len);
    int unsigned s;
    int unsigned n;
    int unsigned sel;
    int unsigned old_len;
    int unsigned final_len;
    logic [7:0]  wt;
    logic [7:0]  c;
    bit          growing;
    s = $urandom_range(0, NUM_SLOTS - 1);
    sel = $urandom_range(0, 19);
    if (full_len || sel == 0) begin
      n = MAX_LEN;
    end else if (sel < 3) begin
      n = $urandom_range(6, MAX_LEN - 1);
    end else begin
      n = $urandom_range(1, 5);
    end
    final_len = (n == MAX_LEN) ? $urandom_range(MAX_LEN, 63) : n;
    wt = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 40));
    growing = 1'($urandom_range(0, 1));
    old_len = pat_len[s];
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        c = 8'($urandom_range(0, 255));
      end else begin
        c = random_case(8'(LOWER_A + $urandom_range(0, 5)));
      end
      load_char(s, i, c, (i == n - 1) ? final_len : (growing ? i + 1 : old_len), wt);
    end
  endtask

  task automatic noise_load();
    load_char($urandom_range(0, NUM_SLOTS - 1), $urandom_range(0, MAX_LEN - 1),
              8'($urandom_range(0, 255)), $urandom_range(0, 63), 8'($urandom_range(0, 255)));
  endtask

  // Scans a run of bytes, optionally closing the file and optionally
  // rewriting the table in the middle of it.
  task automatic scan_bytes(input byte_q_t bytes, input bit close, input bit mid_loads);
    req_t r;
    foreach (bytes[i]) begin
      if (mid_loads && i != 0 && $urandom_range(0, 29) == 0) begin
        noise_load();
      end
      r = random_req();
      r.kind = KIND_SCAN;
      r.data = bytes[i];
      r.last = close && (i == bytes.size() - 1);
      send_req(r);
    end
  endtask

  // A file mixes table patterns in random case with a small alphabet and stray bytes.
  task automatic build_file(output byte_q_t bytes);
    int unsigned n;
    int unsigned s;
    int unsigned pick;
    int          live[$];
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (pat_len[i] != 0) begin
        live = {live, i};
      end
    end
    bytes = {};
    while (bytes.size() < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30 && live.size() != 0) begin
        s = live[$urandom_range(0, live.size() - 1)];
        for (int j = 0; j < pat_len[s]; j++) begin
          bytes = {bytes, random_case(pat_char[s][j])};
        end
      end else if (pick < 85) begin
        bytes = {bytes, random_case(8'(LOWER_A + $urandom_range(0, 5)))};
      end else begin
        bytes = {bytes, 8'($urandom_range(0, 255))};
      end
    end
  endtask

  task automatic run_files(input int unsigned n);
    byte_q_t f;
    repeat (n) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      build_file(f);
      scan_bytes(f, 1'b1, 1'b0);
    end
  endtask

  // Holds the input until every tally has arrived and the pipeline is empty.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_tallies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      REG_DETECT:     thr_detect = val[15:0];
      REG_STRONG:     thr_strong = val[15:0];
      REG_WEAK:       thr_weak   = val[15:0];
      REG_SIZE_LIMIT: size_lim   = val;
      REG_SIZE_BONUS: size_bonus = val[7:0];
      default: ;
    endcase
  endtask

  // Reprograms every register while the block is idle; the spare index must be ignored.
  task automatic write_regs(input logic [15:0] detect, input logic [15:0] strong_thr,
                            input logic [15:0] weak_thr, input logic [31:0] limit,
                            input logic [7:0] bonus);
    drain_results();
    cfg_write(REG_DETECT, detect);
    cfg_write(REG_STRONG, strong_thr);
    cfg_write(REG_WEAK, weak_thr);
    cfg_write(REG_SIZE_LIMIT, limit);
    cfg_write(REG_SIZE_BONUS, bonus);
    cfg_write(REG_SPARE, $urandom);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_config();
    logic [15:0] w;
    logic [15:0] d;
    logic [15:0] s;
    logic [31:0] lim;
    if ($urandom_range(0, 3) != 0) begin
      w = 16'($urandom_range(0, 200));
      d = w + 16'($urandom_range(0, 200));
      s = d + 16'($urandom_range(0, 200));
    end else begin
      w = 16'($urandom_range(0, 600));
      d = 16'($urandom_range(0, 600));
      s = 16'($urandom_range(0, 600));
    end
    lim = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20);
    write_regs(d, s, w, lim, 8'($urandom_range(0, 255)));
  endtask

  // Directed cases under the reset configuration: case folding, duplicate
  // slots, fold boundaries, one-byte files and a table rewrite mid-file.
  task automatic test_basic_matching();
    byte_q_t f;
    gap_max = 0;
    load_char(0, 0, "A", 1, 8'd0);
    load_char(0, 1, "b", 2, 8'd30);
    load_char(1, 0, "b", 1, 8'd30);
    load_char(2, 0, "B", 1, 8'd255);
    load_char(63, 31, 8'hFF, 0, 8'd255);
    load_char(63, 0, "@", 1, 8'd255);
    f = '{"x", "A", "B"};
    scan_bytes(f, 1'b1, 1'b0);
    // A pattern seen several times counts once.
    f = '{"b", "b", "b"};
    scan_bytes(f, 1'b1, 1'b0);
    // Bytes just outside the upper-case range must not fold.
    f = '{8'h00, 8'hFF, "[", "@"};
    scan_bytes(f, 1'b1, 1'b0);
    f = '{"Z"};
    scan_bytes(f, 1'b1, 1'b0);
    // The partial match on "a" survives the slot being rewritten to "ac".
    f = '{"a"};
    scan_bytes(f, 1'b0, 1'b0);
    load_char(0, 1, "c", 2, 8'd0);
    f = '{"c"};
    scan_bytes(f, 1'b1, 1'b0);
  endtask

  // Register extremes, including thresholds in an inconsistent order.
  task automatic test_threshold_extremes();
    write_regs(16'd0, 16'hFFFF, 16'hFFFF, 32'd0, 8'd255);
    load_random_pattern(1'b1);
    run_files(4);
    write_regs(16'hFFFF, 16'd0, 16'd0, 32'hFFFF_FFFF, 8'd0);
    load_random_pattern(1'b0);
    run_files(4);
    write_regs(16'd60, 16'd10, 16'd40, 32'd3, 8'd1);
    run_files(4);
  endtask

  // Mostly whole patterns and files, with stray loads, pauses and reconfiguration.
  task automatic test_random_traffic();
    int unsigned start;
    int unsigned pick;
    byte_q_t     f;
    random_config();
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        load_random_pattern(1'b0);
      end else if (pick < 18) begin
        noise_load();
      end else if (pick < 21) begin
        drain_results();
      end else if (pick < 23) begin
        random_config();
      end else begin
        build_file(f);
        scan_bytes(f, 1'b1, 1'b1);
      end
    end
  endtask

  // The receiver picks a new stall pattern whenever its random stall countdown runs out.
  always @(posedge clk_i) begin
    wave_count <= wave_count + 4'd1;
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_stall_i <= 1'b0;
      STALL_SPARSE: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_WAVE:   out_stall_i <= wave_count[3];
      default:      out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Each accepted tally is compared against the oldest one predicted.
  always @(posedge clk_i) begin
    file_tally_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tallies.size() == 0) begin
        report_mismatch("unexpected tally, score", score_o, 0);
      end else begin
        want = expected_tallies.pop_front();
        if (score_o !== want.score) begin
          report_mismatch("score", score_o, want.score);
        end
        if (match_count_o !== want.count) begin
          report_mismatch("match_count", match_count_o, want.count);
        end
        if (is_client_o !== want.client) begin
          report_mismatch("is_client", is_client_o, want.client);
        end
        if (verdict_o !== want.grade) begin
          report_mismatch("verdict", verdict_o, want.grade);
        end
      end
    end
  end

  // Ends a hung run: no item in, no tally out and no register write for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_matching();
    test_threshold_extremes();
    test_random_traffic();
    drain_results();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wss_pkg.sv
rtl/wss_front.sv
rtl/wss_match.sv
rtl/wss_tally.sv
rtl/weighted_signature_scan.sv
sim/testbench.sv
